// File: rtl/i2c_master_byte_sequencer_defines.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define I2CMBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, held off during reset.
`define I2CMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// File: rtl/i2cmbs_pkg.sv
package i2cmbs_pkg;

    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [9:0] POLL_RESET = 10'd500;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nacked;
    } t_result;

endpackage

// File: rtl/i2c_master_byte_sequencer.sv
// Byte-level I2C master sequencer, one bus phase per input transfer.
// Input channel (i_in_valid / o_in_stall): each transfer is one phase tick
// carrying the sampled SDA level; when idle it may also start a start, stop,
// byte write or byte read command (i_func).
// Output channel (o_out_valid / i_out_stall): exactly one result per input
// transfer, giving the SCL/SDA levels for the phase, busy, done, the last
// received byte and the no-acknowledge flag.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): writes the
// acknowledge poll limit; write only while idle.
// The result is registered: valid the cycle after the input transfer unless
// the output is stalled. Throughput: one transfer per cycle while o_in_stall
// is low; the phase update from the state registers is combinational.
// A two-entry result buffer sits on the output: with the receiver stalled,
// one further input transfer is taken, then o_in_stall rises until the
// receiver takes a result.
// Reset (synchronous, active low): idle, SCL and SDA released, poll limit
// 500, received byte and no-acknowledge flag cleared, no result pending.
`include "i2c_master_byte_sequencer_defines.svh"

module i2c_master_byte_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_nacked
);
    import i2cmbs_pkg::*;

    t_result result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    in_take, out_take, out_free;

    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || out_take;

    i2cmbs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_take),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_in    (i_sda_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_take) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_take) begin
            if (out_free) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_out.scl_level;
    assign o_sda_level = r_out.sda_level;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_rx_byte   = r_out.rx_byte;
    assign o_nacked    = r_out.nacked;

    `I2CMBS_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `I2CMBS_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res)
    `I2CMBS_ASSERT_NEXT(a_stalled_take_fills_skid, i_clk, i_rst_n, in_take && r_out_valid && i_out_stall, r_skid_valid && r_out_valid)
    `I2CMBS_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, in_take, r_out_valid)

endmodule

// File: rtl/i2cmbs_core.sv
module i2cmbs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [2:0]           i_func,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_send_ack,
    input  logic                 i_sda_in,
    input  logic                 i_cfg_we,
    input  logic [9:0]           i_cfg_data,
    output i2cmbs_pkg::t_result  o_result
);
    import i2cmbs_pkg::*;

    localparam logic [3:0] ST_P0 = 4'd0;
    localparam logic [3:0] ST_P1 = 4'd1;
    localparam logic [3:0] ST_P2 = 4'd2;
    localparam logic [3:0] ST_P3 = 4'd3;
    localparam logic [3:0] ST_P4 = 4'd4;
    localparam logic [3:0] ST_P5 = 4'd5;
    localparam logic [3:0] ST_P6 = 4'd6;
    localparam logic [3:0] ST_P7 = 4'd7;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    logic [9:0] r_poll_limit;
    logic [3:0] r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic [9:0] r_poll_count, n_poll_count;
    logic [2:0] r_op, n_op;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_nack, n_nack;
    logic [7:0] r_rx_last, n_rx_last;
    logic       done;
    logic       start_cmd;
    logic [3:0] bit_inc;
    logic [9:0] poll_inc;

    assign start_cmd = (r_op == OP_IDLE) && (i_func inside {[OP_START:OP_READ]});

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_poll_count = r_poll_count;
        n_op         = r_op;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_nack       = r_nack;
        n_rx_last    = r_rx_last;
        done         = 1'b0;

        if (start_cmd) begin
            n_op         = i_func;
            n_phase      = ST_P0;
            n_bit_count  = 4'd0;
            n_poll_count = 10'd0;
            n_ack_choice = i_send_ack;
            n_shift      = (i_func == OP_WRITE) ? i_data_byte : 8'd0;
        end

        bit_inc  = n_bit_count + 4'd1;
        poll_inc = n_poll_count + 10'd1;

        case (n_op)
            OP_IDLE: begin
            end
            OP_START: begin
                case (n_phase)
                    ST_P0: begin n_sda = 1'b1; n_phase = ST_P1; end
                    ST_P1: begin n_scl = 1'b1; n_phase = ST_P2; end
                    ST_P2: begin n_sda = 1'b0; n_phase = ST_P3; end
                    ST_P3: begin n_scl = 1'b0; done = 1'b1; end
                    default: done = 1'b1;
                endcase
            end
            OP_STOP: begin
                case (n_phase)
                    ST_P0: begin n_sda = 1'b0; n_phase = ST_P1; end
                    ST_P1: begin n_scl = 1'b1; n_phase = ST_P2; end
                    ST_P2: begin n_sda = 1'b1; n_phase = ST_P3; end
                    default: done = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (n_phase)
                    ST_P0: begin n_sda = n_shift[7]; n_phase = ST_P1; end
                    ST_P1: begin n_scl = 1'b1; n_phase = ST_P2; end
                    ST_P2: begin
                        n_scl       = 1'b0;
                        n_shift     = {n_shift[6:0], 1'b0};
                        n_bit_count = bit_inc;
                        n_phase     = (bit_inc >= BITS_PER_BYTE) ? ST_P3 : ST_P0;
                    end
                    ST_P3: begin n_sda = 1'b1; n_phase = ST_P4; end
                    ST_P4: begin n_scl = 1'b1; n_phase = ST_P5; end
                    ST_P5: begin
                        if (!i_sda_in) begin
                            n_nack  = 1'b0;
                            n_phase = ST_P6;
                        end else begin
                            n_poll_count = poll_inc;
                            if (poll_inc >= r_poll_limit || poll_inc == 10'd0) begin
                                n_nack  = 1'b1;
                                n_phase = ST_P6;
                            end
                        end
                    end
                    ST_P6: begin n_scl = 1'b0; done = 1'b1; end
                    default: done = 1'b1;
                endcase
            end
            OP_READ: begin
                case (n_phase)
                    ST_P0: begin n_sda = 1'b1; n_phase = ST_P1; end
                    ST_P1: begin n_scl = 1'b1; n_phase = ST_P2; end
                    ST_P2: begin
                        n_shift = {n_shift[6:0], i_sda_in};
                        n_scl   = 1'b0;
                        n_phase = ST_P3;
                    end
                    ST_P3: begin
                        n_bit_count = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            n_rx_last = n_shift;
                            n_phase   = ST_P4;
                        end else begin
                            n_phase = ST_P1;
                        end
                    end
                    ST_P4: begin n_sda = n_ack_choice; n_phase = ST_P5; end
                    ST_P5: begin n_scl = 1'b1; n_phase = ST_P6; end
                    ST_P6: begin n_scl = 1'b0; n_phase = ST_P7; end
                    ST_P7: begin n_sda = ~n_ack_choice; done = 1'b1; end
                    default: done = 1'b1;
                endcase
            end
            default: done = 1'b1;
        endcase

        if (done) begin
            n_op        = OP_IDLE;
            n_phase     = ST_P0;
            n_bit_count = 4'd0;
        end
    end

    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.busy_res  = (n_op != OP_IDLE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_rx_last;
        o_result.nacked    = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_RESET;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ST_P0;
            r_bit_count  <= 4'd0;
            r_shift      <= 8'd0;
            r_poll_count <= 10'd0;
            r_op         <= OP_IDLE;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_nack       <= 1'b0;
            r_rx_last    <= 8'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_poll_count <= n_poll_count;
            r_op         <= n_op;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_nack       <= n_nack;
            r_rx_last    <= n_rx_last;
        end
    end

endmodule
